/* rtl/jrgb_pkg.sv */
// Shared constants and types for the level-to-jet RGBA color mapper.
// Used by jrgb_front, jrgb_cell and level_to_jet_rgba_top; no dependencies.
package jrgb_pkg;

  // fixed-point format of the level values
  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_W      = 16;
  localparam int COLOR_W       = 8;

  // one lane per color channel: red, green, blue
  localparam int LANES      = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // divider sizing: quotient is below 256, one quotient bit per cell
  localparam int QUO_W     = COLOR_W;
  localparam int NUM_CELLS = QUO_W;
  localparam int RANGE_W   = 16;                 // max_level - min_level, clamped
  localparam int DIV_W     = RANGE_W + 1 + QUO_W - 1; // (2 * range) << 7
  localparam int REM_W     = RANGE_W + 1 + QUO_W;     // below (2 * range) << 8
  localparam int TENT_W    = RANGE_W + 2;              // |4d - k*r|
  localparam int NUM_W     = TENT_W + 2;               // 3r - 2a, signed

  // level constants in raw fixed point
  localparam int CUT_OFFSET = 10 << FRACTION_BITS;
  localparam int TENTH      = (1 << FRACTION_BITS) / 10;
  localparam int UNIT_RANGE = 1 << FRACTION_BITS;

  // register reset values
  localparam logic [SAMPLE_W-1:0] MIN_LEVEL_RESET = 16'd0;
  localparam logic [SAMPLE_W-1:0] MAX_LEVEL_RESET = 16'd30720;

  // output constants
  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] ALPHA_ON   = 8'd200;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL = 1'b0,
    REG_MAX_LEVEL = 1'b1
  } cfg_reg_t;

  // data handed from cell to cell
  typedef struct packed {
    logic                              cut;   // sample below cut-off
    logic [LANES-1:0]                  full;  // tent saturated at 1
    logic [LANES-1:0]                  zero;  // tent at or below 0
    logic [DIV_W-1:0]                  div_hi; // divisor aligned to top quotient bit
    logic [LANES-1:0][REM_W-1:0]       rem;
    logic [LANES-1:0][QUO_W-1:0]       quo;
  } cell_data_t;

endpackage

/* rtl/jrgb_front.sv */
// Front end of the jet color mapper: cut-off test, normalization and tent
// numerators over three pipeline stages. Depends on jrgb_pkg.
module jrgb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [jrgb_pkg::SAMPLE_W-1:0]     min_level,
  input  logic [jrgb_pkg::SAMPLE_W-1:0]     max_level,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [jrgb_pkg::SAMPLE_W-1:0]     level_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output jrgb_pkg::cell_data_t              out_data
);

  // stage registers
  logic                                     a_valid;
  logic                                     a_cut;
  logic [jrgb_pkg::RANGE_W-1:0]             a_r;
  logic [jrgb_pkg::RANGE_W-1:0]             a_d;
  logic                                     b_valid;
  logic                                     b_cut;
  logic [jrgb_pkg::RANGE_W-1:0]             b_r;
  logic [jrgb_pkg::TENT_W-1:0]              b_r3;
  logic [jrgb_pkg::LANES-1:0][jrgb_pkg::TENT_W-1:0] b_a;
  logic                                     c_valid;
  jrgb_pkg::cell_data_t                     c_data;

  // stage a combinational values
  logic signed [jrgb_pkg::SAMPLE_W+1:0]     s_ext;
  logic signed [jrgb_pkg::SAMPLE_W+1:0]     low_cut;
  logic signed [jrgb_pkg::SAMPLE_W:0]       rdiff;
  logic signed [jrgb_pkg::SAMPLE_W:0]       dd;
  logic                                     cut_next;
  logic [jrgb_pkg::RANGE_W-1:0]             r_next;
  logic [jrgb_pkg::RANGE_W-1:0]             d_next;

  // stage b combinational values
  logic [jrgb_pkg::LANES-1:0][jrgb_pkg::TENT_W-1:0] kr;
  logic signed [jrgb_pkg::TENT_W:0]         e [jrgb_pkg::LANES];
  logic signed [jrgb_pkg::TENT_W:0]         e_abs [jrgb_pkg::LANES];
  logic [jrgb_pkg::LANES-1:0][jrgb_pkg::TENT_W-1:0] a_next;

  // stage c combinational values
  logic signed [jrgb_pkg::NUM_W-1:0]        num [jrgb_pkg::LANES];
  logic [jrgb_pkg::RANGE_W:0]               n_low [jrgb_pkg::LANES];
  jrgb_pkg::cell_data_t                     c_next;

  logic                                     a_ready;
  logic                                     b_ready;
  logic                                     c_ready;

  // ready chain: a stage takes data when empty or when it is moving on
  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // stage a: cut-off test, range and clamped offset
  always_comb begin
    s_ext   = {{2{level_sample[jrgb_pkg::SAMPLE_W-1]}}, level_sample};
    low_cut = $signed({{2{min_level[jrgb_pkg::SAMPLE_W-1]}}, min_level})
              - $signed((jrgb_pkg::SAMPLE_W+2)'(jrgb_pkg::CUT_OFFSET));
    cut_next = (s_ext < low_cut) ||
               ($signed(level_sample) <= $signed(jrgb_pkg::SAMPLE_W'(jrgb_pkg::TENTH)));
    rdiff = $signed({max_level[jrgb_pkg::SAMPLE_W-1], max_level})
            - $signed({min_level[jrgb_pkg::SAMPLE_W-1], min_level});
    if (rdiff <= 0) begin
      r_next = jrgb_pkg::RANGE_W'(jrgb_pkg::UNIT_RANGE);
    end else begin
      r_next = rdiff[jrgb_pkg::RANGE_W-1:0];
    end
    dd = $signed({level_sample[jrgb_pkg::SAMPLE_W-1], level_sample})
         - $signed({min_level[jrgb_pkg::SAMPLE_W-1], min_level});
    if (dd < 0) begin
      d_next = '0;
    end else if (dd > $signed({1'b0, r_next})) begin
      d_next = r_next;
    end else begin
      d_next = dd[jrgb_pkg::RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_cut <= cut_next;
      a_r   <= r_next;
      a_d   <= d_next;
    end
  end

  // stage b: tent distances |4d - k*r| for k = 3, 2, 1
  always_comb begin
    kr[jrgb_pkg::LANE_RED]   = {1'b0, a_r, 1'b0} + {2'b00, a_r};
    kr[jrgb_pkg::LANE_GREEN] = {1'b0, a_r, 1'b0};
    kr[jrgb_pkg::LANE_BLUE]  = {2'b00, a_r};
    for (int i = 0; i < jrgb_pkg::LANES; i++) begin
      e[i]      = $signed({1'b0, a_d, 2'b00}) - $signed({1'b0, kr[i]});
      e_abs[i]  = (e[i] < 0) ? -e[i] : e[i];
      a_next[i] = e_abs[i][jrgb_pkg::TENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      b_cut <= a_cut;
      b_r   <= a_r;
      b_r3  <= kr[jrgb_pkg::LANE_RED];
      b_a   <= a_next;
    end
  end

  // stage c: numerators 3r - 2a, saturation flags and dividend 255 * num
  always_comb begin
    c_next.cut    = b_cut;
    c_next.div_hi = {b_r, {jrgb_pkg::QUO_W{1'b0}}};
    c_next.quo    = '0;
    for (int i = 0; i < jrgb_pkg::LANES; i++) begin
      num[i] = $signed({2'b00, b_r3}) - $signed({1'b0, b_a[i], 1'b0});
      c_next.zero[i] = (num[i] <= 0);
      c_next.full[i] = (num[i] >= $signed({3'b000, b_r, 1'b0}));
      n_low[i] = num[i][jrgb_pkg::RANGE_W:0];
      c_next.rem[i] = {n_low[i], {jrgb_pkg::QUO_W{1'b0}}}
                      - {{jrgb_pkg::QUO_W{1'b0}}, n_low[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      c_data <= c_next;
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

/* rtl/jrgb_cell.sv */
// One cell of the divider chain: settles one quotient bit for each color
// lane and hands the partial remainders on. Depends on jrgb_pkg.
module jrgb_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jrgb_pkg::cell_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jrgb_pkg::cell_data_t out_data
);

  logic                        valid;
  jrgb_pkg::cell_data_t        data;
  jrgb_pkg::cell_data_t        data_next;
  logic [jrgb_pkg::LANES-1:0]  take;
  logic [jrgb_pkg::REM_W-1:0]  diff [jrgb_pkg::LANES];
  logic [jrgb_pkg::REM_W-1:0]  kept [jrgb_pkg::LANES];

  assign in_ready = !valid || out_ready;

  // restoring step: subtract the aligned divisor when it fits, then shift
  always_comb begin
    data_next = in_data;
    for (int i = 0; i < jrgb_pkg::LANES; i++) begin
      take[i] = (in_data.rem[i] >= {1'b0, in_data.div_hi});
      diff[i] = in_data.rem[i] - {1'b0, in_data.div_hi};
      kept[i] = take[i] ? diff[i] : in_data.rem[i];
      data_next.rem[i] = {kept[i][jrgb_pkg::REM_W-2:0], 1'b0};
      data_next.quo[i] = {in_data.quo[i][jrgb_pkg::QUO_W-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* rtl/level_to_jet_rgba_top.sv */
// Top level of the level-to-jet RGBA mapper: registers, front end, divider
// chain of jrgb_cell and pixel output. Depends on jrgb_pkg, jrgb_front, jrgb_cell.
// Pipeline: 3 front stages, then one stage per quotient bit in the 8-cell
// divider chain.
// Throughput: one sample per clock unless out_ready stalls it; every stage holds
// one item and moves on whenever the stage after it is empty or moving.
// Reset: synchronous, clears all valid bits; min_level resets to 0 and
// max_level to 30720 (120.0 dB).
module level_to_jet_rgba_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jrgb_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [jrgb_pkg::SAMPLE_W-1:0]      level_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jrgb_pkg::COLOR_W-1:0]       red,
  output logic [jrgb_pkg::COLOR_W-1:0]       green,
  output logic [jrgb_pkg::COLOR_W-1:0]       blue,
  output logic [jrgb_pkg::COLOR_W-1:0]       alpha
);

  logic [jrgb_pkg::SAMPLE_W-1:0]   min_level;
  logic [jrgb_pkg::SAMPLE_W-1:0]   max_level;
  logic [jrgb_pkg::NUM_CELLS:0]    chain_valid;
  logic [jrgb_pkg::NUM_CELLS:0]    chain_ready;
  jrgb_pkg::cell_data_t            chain_data [jrgb_pkg::NUM_CELLS+1];
  jrgb_pkg::cell_data_t            last;
  logic [jrgb_pkg::COLOR_W-1:0]    color [jrgb_pkg::LANES];

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= jrgb_pkg::MIN_LEVEL_RESET;
      max_level <= jrgb_pkg::MAX_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (jrgb_pkg::cfg_reg_t'(cfg_index))
        jrgb_pkg::REG_MIN_LEVEL: min_level <= cfg_data;
        jrgb_pkg::REG_MAX_LEVEL: max_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: cut-off, normalization, tent numerators
  jrgb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .min_level    (min_level),
    .max_level    (max_level),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .level_sample (level_sample),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out_data     (chain_data[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar g = 0; g < jrgb_pkg::NUM_CELLS; g++) begin : g_cell
    jrgb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  assign last                                = chain_data[jrgb_pkg::NUM_CELLS];
  assign out_valid                           = chain_valid[jrgb_pkg::NUM_CELLS];
  assign chain_ready[jrgb_pkg::NUM_CELLS]    = out_ready;

  // pixel assembly: cut-off and saturated tents override the quotient
  always_comb begin
    for (int i = 0; i < jrgb_pkg::LANES; i++) begin
      if (last.cut || last.zero[i]) begin
        color[i] = '0;
      end else if (last.full[i]) begin
        color[i] = jrgb_pkg::COLOR_FULL;
      end else begin
        color[i] = last.quo[i];
      end
    end
  end

  assign red   = color[jrgb_pkg::LANE_RED];
  assign green = color[jrgb_pkg::LANE_GREEN];
  assign blue  = color[jrgb_pkg::LANE_BLUE];
  assign alpha = last.cut ? '0 : jrgb_pkg::ALPHA_ON;

endmodule

/* verif/testbench.sv */
// Self-checking bench for level_to_jet_rgba_top: directed table, then random levels.
// Holds its own jet color map predictor; depends on jrgb_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int LONG_HOLD    = 300;     // receiver stall that backs up the pipeline
  localparam int DRAIN_CYCLES = 16;      // pipeline latency plus margin
  localparam int CYCLE_LIMIT  = 300000;
  localparam int BLOCK_ITEMS  = 100;
  localparam int BLOCKS       = 5;

  typedef struct packed {
    logic [jrgb_pkg::COLOR_W-1:0] red;
    logic [jrgb_pkg::COLOR_W-1:0] green;
    logic [jrgb_pkg::COLOR_W-1:0] blue;
    logic [jrgb_pkg::COLOR_W-1:0] alpha;
  } pixel_t;

  localparam pixel_t BLACK     = '0;
  localparam pixel_t TOP_PIXEL = '{red: 8'd127, green: 8'd0, blue: 8'd0,
                                   alpha: jrgb_pkg::ALPHA_ON};

  // one directed transaction, optionally preceded by a new color scale
  typedef struct packed {
    logic                                 new_scale;
    logic signed [jrgb_pkg::SAMPLE_W-1:0] scale_lo;
    logic signed [jrgb_pkg::SAMPLE_W-1:0] scale_hi;
    logic signed [jrgb_pkg::SAMPLE_W-1:0] sample;
    logic                                 pinned;
    pixel_t                               pixel;
  } dir_row_t;

  dir_row_t directed_rows [23] = '{
    // reset scale: cut-off threshold, extremes, mid points
    '{1'b0, 16'sd0, 16'sd0, 16'sd25,     1'b1, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'sd26,     1'b0, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0,      1'b1, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'h8000,    1'b1, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'h7FFF,    1'b1, TOP_PIXEL},
    '{1'b0, 16'sd0, 16'sd0, 16'sd30720,  1'b1, TOP_PIXEL},
    '{1'b0, 16'sd0, 16'sd0, 16'sd15360,  1'b0, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'sd7680,   1'b0, BLACK},
    '{1'b0, 16'sd0, 16'sd0, 16'sd23040,  1'b0, BLACK},
    // raised minimum: edge of the low cut, below min, above max
    '{1'b1, 16'sd5000, 16'sd6000, 16'sd2440, 1'b0, BLACK},
    '{1'b0, 16'sd5000, 16'sd6000, 16'sd2439, 1'b1, BLACK},
    '{1'b0, 16'sd5000, 16'sd6000, 16'sd4999, 1'b0, BLACK},
    '{1'b0, 16'sd5000, 16'sd6000, 16'sd6001, 1'b0, BLACK},
    // widest scale, low cut far below the sample range
    '{1'b1, 16'h8000, 16'h7FFF, 16'sd26,   1'b0, BLACK},
    '{1'b0, 16'h8000, 16'h7FFF, 16'h7FFF,  1'b1, TOP_PIXEL},
    '{1'b0, 16'h8000, 16'h7FFF, 16'h8000,  1'b1, BLACK},
    // empty range falls back to unit range
    '{1'b1, 16'sd3000, 16'sd3000, 16'sd3000, 1'b0, BLACK},
    '{1'b0, 16'sd3000, 16'sd3000, 16'sd3128, 1'b0, BLACK},
    '{1'b0, 16'sd3000, 16'sd3000, 16'sd3256, 1'b0, BLACK},
    // inverted range at the top of the level span
    '{1'b1, 16'h7FFF, 16'h8000, 16'sd30207, 1'b0, BLACK},
    '{1'b0, 16'h7FFF, 16'h8000, 16'sd30206, 1'b1, BLACK},
    '{1'b0, 16'h7FFF, 16'h8000, 16'h7FFF,   1'b0, BLACK},
    '{1'b1, 16'sd0, 16'sd30720, 16'sd100,   1'b0, BLACK}
  };

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [jrgb_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [jrgb_pkg::SAMPLE_W-1:0]        cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [jrgb_pkg::SAMPLE_W-1:0]        level_sample;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [jrgb_pkg::COLOR_W-1:0]         red;
  logic [jrgb_pkg::COLOR_W-1:0]         green;
  logic [jrgb_pkg::COLOR_W-1:0]         blue;
  logic [jrgb_pkg::COLOR_W-1:0]         alpha;

  // predictor copy of the color scale registers
  logic signed [jrgb_pkg::SAMPLE_W-1:0] scale_min;
  logic signed [jrgb_pkg::SAMPLE_W-1:0] scale_max;

  pixel_t expected_pixels [$];
  logic   pinned_valid;
  pixel_t pinned_pixel;
  int     sender_idle_pct;
  int     recv_idle_pct;
  logic   hold_req;
  int     cycle_count;
  int     error_count;
  int     pixels_checked;
  int     cut_count;
  int     reg_writes;

  level_to_jet_rgba_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .level_sample (level_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // floor(255 * clamp(1.5 - |4*gap/span - k|)), exact in integers
  function automatic logic [jrgb_pkg::COLOR_W-1:0] jet_tent(longint gap, longint span,
                                                            longint k);
    longint offset;
    longint height;
    offset = 4 * gap - k * span;
    if (offset < 0) offset = -offset;
    height = 3 * span - 2 * offset;
    if (height <= 0) return '0;
    if (height >= 2 * span) return jrgb_pkg::COLOR_FULL;
    return jrgb_pkg::COLOR_W'((255 * height) / (2 * span));
  endfunction

  function automatic pixel_t jet_pixel(logic signed [jrgb_pkg::SAMPLE_W-1:0] sample);
    longint lvl;
    longint low_cut;
    longint span;
    longint gap;
    pixel_t px;
    lvl     = sample;
    low_cut = longint'(scale_min) - jrgb_pkg::CUT_OFFSET;
    if (lvl < low_cut || lvl <= jrgb_pkg::TENTH) return BLACK;
    span = longint'(scale_max) - longint'(scale_min);
    if (span <= 0) span = jrgb_pkg::UNIT_RANGE;
    gap = lvl - scale_min;
    if (gap < 0) gap = 0;
    if (gap > span) gap = span;
    px.red   = jet_tent(gap, span, 3);
    px.green = jet_tent(gap, span, 2);
    px.blue  = jet_tent(gap, span, 1);
    px.alpha = jrgb_pkg::ALPHA_ON;
    return px;
  endfunction

  function automatic logic [jrgb_pkg::SAMPLE_W-1:0] clamp_level(int lvl);
    if (lvl < -32768) return 16'h8000;
    if (lvl > 32767) return 16'h7FFF;
    return jrgb_pkg::SAMPLE_W'(lvl);
  endfunction

  // random level, weighted toward the thresholds and the active scale
  function automatic logic [jrgb_pkg::SAMPLE_W-1:0] pick_level();
    int lo;
    int hi;
    lo = int'(scale_min) - jrgb_pkg::CUT_OFFSET - 16;
    hi = int'(scale_max) + 16;
    if (hi <= lo) hi = lo + 2 * jrgb_pkg::UNIT_RANGE;
    case ($urandom_range(9))
      0, 1: return jrgb_pkg::SAMPLE_W'($urandom);
      2: return clamp_level(jrgb_pkg::TENTH - 6 + int'($urandom_range(12)));
      3: return clamp_level(int'(scale_min) - jrgb_pkg::CUT_OFFSET - 6
                            + int'($urandom_range(12)));
      4: return clamp_level(int'(scale_min) - 6 + int'($urandom_range(12)));
      5: return clamp_level(int'(scale_max) - 6 + int'($urandom_range(12)));
      default: return clamp_level(lo + int'($urandom_range(hi - lo)));
    endcase
  endfunction

  task automatic report_field(string name, logic [jrgb_pkg::COLOR_W-1:0] want,
                              logic [jrgb_pkg::COLOR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // call in a falling-edge step; returns in a later falling-edge step
  task automatic send_sample(logic [jrgb_pkg::SAMPLE_W-1:0] sample, logic pin, pixel_t pix);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pinned_valid = pin;
    pinned_pixel = pix;
    in_valid     <= 1'b1;
    level_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pinned_valid = 1'b0;
  endtask

  task automatic write_reg(jrgb_pkg::cfg_reg_t index, logic [jrgb_pkg::SAMPLE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic pick_scale(int mode);
    logic signed [jrgb_pkg::SAMPLE_W-1:0] lo;
    logic signed [jrgb_pkg::SAMPLE_W-1:0] hi;
    logic signed [jrgb_pkg::SAMPLE_W-1:0] tmp;
    lo = jrgb_pkg::SAMPLE_W'($urandom);
    hi = jrgb_pkg::SAMPLE_W'($urandom);
    case (mode)
      0: begin
        if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      1: begin
        lo = jrgb_pkg::SAMPLE_W'(int'($urandom_range(6000)) - 2000);
        hi = jrgb_pkg::SAMPLE_W'(int'(lo) + int'($urandom_range(4000, 1)));
      end
      2: ;
      3: hi = lo;
      default: begin
        lo = jrgb_pkg::MIN_LEVEL_RESET;
        hi = jrgb_pkg::MAX_LEVEL_RESET;
      end
    endcase
    write_reg(jrgb_pkg::REG_MIN_LEVEL, lo);
    write_reg(jrgb_pkg::REG_MAX_LEVEL, hi);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // register tracking, expectation store and pixel comparison
  always @(posedge clk) begin : scoreboard
    pixel_t want;
    pixel_t got;
    if (rst) begin
      scale_min = jrgb_pkg::MIN_LEVEL_RESET;
      scale_max = jrgb_pkg::MAX_LEVEL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          jrgb_pkg::REG_MIN_LEVEL: scale_min = cfg_data;
          jrgb_pkg::REG_MAX_LEVEL: scale_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(pinned_valid ? pinned_pixel : jet_pixel(level_sample));
      if (out_valid && out_ready) begin
        got = '{red, green, blue, alpha};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $time,
                   red, green, blue, alpha);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (want.alpha == 0) cut_count++;
          report_field("red", want.red, got.red);
          report_field("green", want.green, got.green);
          report_field("blue", want.blue, got.blue);
          report_field("alpha", want.alpha, got.alpha);
        end
      end
    end
  end

  // output side: random back-pressure plus one long stall on request
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = jrgb_pkg::REG_MIN_LEVEL;
    cfg_data        = '0;
    in_valid        = 1'b0;
    level_sample    = '0;
    pinned_valid    = 1'b0;
    pinned_pixel    = BLACK;
    hold_req        = 1'b0;
    sender_idle_pct = 30;
    recv_idle_pct   = 30;
    cycle_count     = 0;
    error_count     = 0;
    pixels_checked  = 0;
    cut_count       = 0;
    reg_writes      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].new_scale) begin
        in_valid <= 1'b0;
        drain();
        write_reg(jrgb_pkg::REG_MIN_LEVEL, directed_rows[i].scale_lo);
        write_reg(jrgb_pkg::REG_MAX_LEVEL, directed_rows[i].scale_hi);
      end
      send_sample(directed_rows[i].sample, directed_rows[i].pinned, directed_rows[i].pixel);
    end

    // random phases: sender-light idling, receiver-light idling, none
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 80 : 0;
      recv_idle_pct   = (phase == 0) ? 80 : (phase == 1) ? 30 : 0;
      for (int blk = 0; blk < BLOCKS; blk++) begin
        in_valid <= 1'b0;
        drain();
        pick_scale(blk);
        if (phase == 2 && blk == 0) hold_req = 1'b1;
        for (int n = 0; n < BLOCK_ITEMS; n++)
          send_sample(pick_level(), 1'b0, BLACK);
      end
    end

    in_valid <= 1'b0;
    drain();
    $display("checked %0d pixels, %0d of them cut off, across %0d register writes",
             pixels_checked, cut_count, reg_writes);
    $display("scales covered: reset, extremes, empty, inverted and random; %0d mismatches",
             error_count);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
